FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/shu_pkg.sv
// ---------------------------------------------------------------------------
// shu_pkg
// Payload types, fixed-point constants and polynomial coefficients
// ---------------------------------------------------------------------------
package shu_pkg;

  localparam int TRIPLE_Q8  = 69929;
  localparam int LIQ_MAX_Q8 = 25600;
  localparam int ICE_MIN_Q8 = -15360;
  localparam int P21_MAX    = 2097151;
  localparam int Q24_ONE    = 16777216;
  localparam logic [32:0] PA16_MAX = 33'(P21_MAX) << 12;
  // reciprocal of 625 for the divide by ten thousand
  localparam logic [24:0] R625 = 25'((64'd1 << 34) / 625);

  typedef struct packed {
    logic [16:0] temp_kelvin;
    logic [20:0] vapor_press;
    logic [20:0] air_press;
    logic [24:0] spec_humidity;
  } shu_in_t;

  typedef struct packed {
    logic [20:0] sat_press;
    logic [20:0] sat_press_slope;
    logic [24:0] sat_humidity;
    logic [24:0] humidity_slope;
  } shu_out_t;

  // decimal mantissa times ten to the minus exp10, rounded to signed Q40
  function automatic logic signed [55:0] q40(input logic [31:0] mant, input int exp10,
                                              input logic neg);
    logic [127:0] d;
    logic [127:0] num;
    logic [127:0] rem;
    logic [127:0] quo;
    int i;
    d = 128'd1;
    for (i = 0; i < exp10; i++) d = d * 128'd10;
    num = ({96'd0, mant} << 41) + d;
    rem = '0;
    quo = '0;
    for (i = 127; i >= 0; i--) begin
      rem = {rem[126:0], num[i]};
      if (rem >= (d << 1)) begin
        rem = rem - (d << 1);
        quo[i] = 1'b1;
      end
    end
    return neg ? -$signed(quo[55:0]) : $signed(quo[55:0]);
  endfunction

  // rows: liquid esat, ice esat, liquid slope, ice slope; entry k multiplies C^k
  localparam logic signed [55:0] COEF [4][7] = '{
    '{q40(61078000, 7, 1'b0), q40(44365185, 8, 1'b0), q40(14289458, 9, 1'b0),
      q40(26506485, 11, 1'b0), q40(30312404, 13, 1'b0), q40(20340809, 15, 1'b0),
      q40(61368209, 18, 1'b0)},
    '{q40(61091780, 7, 1'b0), q40(50346990, 8, 1'b0), q40(18860134, 9, 1'b0),
      q40(41762237, 11, 1'b0), q40(58247203, 13, 1'b0), q40(48388032, 15, 1'b0),
      q40(18388269, 17, 1'b0)},
    '{q40(44381000, 8, 1'b0), q40(28570026, 9, 1'b0), q40(79380540, 11, 1'b0),
      q40(12152151, 12, 1'b0), q40(10365614, 14, 1'b0), q40(35324218, 17, 1'b0),
      q40(70902448, 19, 1'b1)},
    '{q40(50303052, 8, 1'b0), q40(37732550, 9, 1'b0), q40(12679954, 10, 1'b0),
      q40(24775631, 12, 1'b0), q40(30056931, 14, 1'b0), q40(21585425, 16, 1'b0),
      q40(71310977, 19, 1'b0)}
  };

endpackage

FILE: rtl/shu_chan_if.sv
// ---------------------------------------------------------------------------
// shu_chan_if
// Valid/ready channel carrying one request payload of type T
// ---------------------------------------------------------------------------
interface shu_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/saturation_humidity_unit.sv
// ---------------------------------------------------------------------------
// saturation_humidity_unit: throughput one request per cycle unless stalled
// 43-stage pipeline, the last stage is the output register: six Horner steps, then two
// 25-step restoring dividers in lockstep; a stall freezes every stage at once
// reset clears only the stage valid bits, no clearing pass
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module saturation_humidity_unit (
  input  logic        clk,
  input  logic        rst,
  shu_chan_if.sink    sample,
  shu_chan_if.source  result
);

  localparam int LAST = 42;

  typedef struct packed {
    logic [55:0] num;
    logic [30:0] den;
    logic        pos;
  } hq_t;

  typedef struct packed {
    logic [32:0] hr;
    logic [32:0] hd;
    logic [24:0] hl;
    logic [24:0] hqo;
    logic        hsat;
    logic        hzero;
    logic [30:0] sr;
    logic [30:0] sd;
    logic [24:0] sl;
    logic [24:0] sqo;
    logic        spos;
    logic [20:0] press;
    logic [20:0] slope;
  } div_t;

  typedef struct packed {
    logic [20:0] press;
    logic [20:0] slope;
  } op_t;

  function automatic logic signed [55:0] cf(input logic slp, input logic warm,
                                            input logic [2:0] k);
    logic [1:0] row;
    row = {slp, ~warm};
    return shu_pkg::COEF[row][k];
  endfunction

  // round a Q8 product half away from zero
  function automatic logic signed [55:0] mq8(input logic signed [71:0] p);
    logic signed [71:0] s;
    s = p + (p[71] ? 72'sd127 : 72'sd128);
    return s[63:8];
  endfunction

  // hPa Q40 magnitude times 100 to pascal Q16, clamped
  function automatic logic [32:0] pa16(input logic [61:0] m, input logic np);
    logic [37:0] r;
    r = 38'((m + 62'(1 << 23)) >> 24);
    if (np) return '0;
    if (r > 38'(shu_pkg::PA16_MAX)) return shu_pkg::PA16_MAX;
    return r[32:0];
  endfunction

  function automatic logic [20:0] out21(input logic [32:0] v);
    logic [33:0] r;
    r = ({1'b0, v} + 34'd2048) >> 12;
    if (r > 34'(shu_pkg::P21_MAX)) return 21'(shu_pkg::P21_MAX);
    return r[20:0];
  endfunction

  // one quotient bit of both dividers
  function automatic div_t div_step(input div_t a);
    div_t       b;
    logic [33:0] hr2;
    logic [31:0] sr2;
    b = a;
    hr2 = {a.hr, a.hl[24]};
    if (hr2 >= {1'b0, a.hd}) begin
      b.hr  = 33'(hr2 - {1'b0, a.hd});
      b.hqo = {a.hqo[23:0], 1'b1};
    end else begin
      b.hr  = hr2[32:0];
      b.hqo = {a.hqo[23:0], 1'b0};
    end
    b.hl = {a.hl[23:0], 1'b0};
    sr2 = {a.sr, a.sl[24]};
    if (sr2 >= {1'b0, a.sd}) begin
      b.sr  = 31'(sr2 - {1'b0, a.sd});
      b.sqo = {a.sqo[23:0], 1'b1};
    end else begin
      b.sr  = sr2[30:0];
      b.sqo = {a.sqo[23:0], 1'b0};
    end
    b.sl = {a.sl[23:0], 1'b0};
    return b;
  endfunction

  logic [LAST:0]      vld;
  logic               en;

  logic signed [15:0] x_d [0:10];
  logic               warm_d [0:11];
  logic [20:0]        e0, p0;
  logic [24:0]        q_d [0:4];

  logic signed [71:0] prod_e [0:5];
  logic signed [71:0] prod_d [0:5];
  logic signed [55:0] acc_e [0:5];
  logic signed [55:0] acc_d [0:5];

  logic [61:0]        e100, d100;
  logic               enp, dnp;
  logic [32:0]        es14, ds14, es15;
  logic [59:0]        p15;
  op_t                op15;

  logic [37:0]        tn1;
  logic [33:0]        m2, m3;
  logic [58:0]        pr2;
  logic [24:0]        qe3, t4;
  logic [50:0]        qf5;
  logic [26:0]        g_d [0:8];

  logic [30:0]        qa1, qc1, qc2;
  logic [29:0]        qb1;
  logic signed [31:0] qdf2;
  hq_t                hq_d [0:12];
  hq_t                hq3;

  div_t               dv [0:25];
  div_t               dv0, dv_next [1:25];
  shu_pkg::shu_out_t  out_q;

  logic signed [17:0] cel;
  logic               warm_in;
  logic signed [17:0] x_in;
  logic [60:0]        n15;

  // global advance: the last stage is the output register
  assign en           = !vld[LAST] || result.ready;
  assign sample.ready = en;
  assign result.valid = vld[LAST];
  assign result.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], sample.valid};
    end
  end

  // celsius offset and clamp per phase
  always_comb begin
    cel     = $signed({1'b0, sample.data.temp_kelvin}) - 18'(shu_pkg::TRIPLE_Q8);
    warm_in = sample.data.temp_kelvin >= 17'(shu_pkg::TRIPLE_Q8);
    if (warm_in) begin
      x_in = (cel > 18'(shu_pkg::LIQ_MAX_Q8)) ? 18'(shu_pkg::LIQ_MAX_Q8) : cel;
    end else begin
      x_in = (cel < 18'(shu_pkg::ICE_MIN_Q8)) ? 18'(shu_pkg::ICE_MIN_Q8) : cel;
    end
  end

  // input stage and delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      x_d[0]    <= x_in[15:0];
      warm_d[0] <= warm_in;
      e0        <= sample.data.vapor_press;
      p0        <= sample.data.air_press;
      q_d[0]    <= sample.data.spec_humidity;
      for (int i = 1; i <= 10; i++) x_d[i] <= x_d[i-1];
      for (int i = 1; i <= 11; i++) warm_d[i] <= warm_d[i-1];
      for (int i = 1; i <= 4; i++) q_d[i] <= q_d[i-1];
    end
  end

  // horner steps: multiply stage, then round and add coefficient stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod_e[0] <= cf(1'b0, warm_d[0], 3'd6) * x_d[0];
      prod_d[0] <= cf(1'b1, warm_d[0], 3'd6) * x_d[0];
      for (int h = 1; h < 6; h++) begin
        prod_e[h] <= acc_e[h-1] * x_d[2*h];
        prod_d[h] <= acc_d[h-1] * x_d[2*h];
      end
      for (int h = 0; h < 6; h++) begin
        acc_e[h] <= cf(1'b0, warm_d[2*h+1], 3'(5-h)) + mq8(prod_e[h]);
        acc_d[h] <= cf(1'b1, warm_d[2*h+1], 3'(5-h)) + mq8(prod_d[h]);
      end
    end
  end

  // unit conversion to pascal Q16 and output rounding
  always_ff @(posedge clk) begin
    if (en) begin
      e100       <= 62'(acc_e[5][54:0]) * 62'd100;
      d100       <= 62'(acc_d[5][54:0]) * 62'd100;
      enp        <= acc_e[5][55] || (acc_e[5] == '0);
      dnp        <= acc_d[5][55] || (acc_d[5] == '0);
      es14       <= pa16(e100, enp);
      ds14       <= pa16(d100, dnp);
      es15       <= es14;
      p15        <= 60'(ds14) * 60'(g_d[8]);
      op15.press <= out21(es14);
      op15.slope <= out21(ds14);
    end
  end

  // humidity factor q*(1 + 0.6077q)
  always_ff @(posedge clk) begin
    if (en) begin
      tn1    <= 38'(q_d[0]) * 38'd6077 + 38'd5000;
      m2     <= tn1[37:4];
      pr2    <= 59'(tn1[37:4]) * 59'(shu_pkg::R625);
      qe3    <= pr2[58:34];
      m3     <= m2;
      t4     <= qe3 + 25'((m3 - 34'(qe3) * 34'd625) >= 34'd625);
      qf5    <= 51'(q_d[4]) * 51'(26'(shu_pkg::Q24_ONE) + 26'(t4));
      g_d[0] <= 27'((qf5 + 51'(1 << 23)) >> 24);
      for (int i = 1; i <= 8; i++) g_d[i] <= g_d[i-1];
    end
  end

  // saturation humidity divisor and numerator
  always_comb begin
    if (qdf2 < $signed({1'b0, qc2})) begin
      hq3.den = qc2;
      hq3.pos = qc2 != '0;
    end else begin
      hq3.den = qdf2[30:0];
      hq3.pos = qdf2 != '0;
    end
    hq3.num = {1'b0, qc2, 24'd0} + 56'(hq3.den >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa1     <= 31'(p0) * 31'd1000;
      qb1     <= 30'(e0) * 30'd378;
      qc1     <= 31'(e0) * 31'd622;
      qdf2    <= $signed({1'b0, qa1}) - $signed({2'b0, qb1});
      qc2     <= qc1;
      hq_d[0] <= hq3;
      for (int i = 1; i <= 12; i++) hq_d[i] <= hq_d[i-1];
    end
  end

  // divider entry
  always_comb begin
    n15       = 61'(p15) + 61'(es15 >> 1);
    dv0.hd    = es15;
    dv0.hr    = n15[57:25];
    dv0.hl    = n15[24:0];
    dv0.hqo   = '0;
    dv0.hsat  = n15[60:25] >= 36'(es15);
    dv0.hzero = es15 == '0;
    dv0.sd    = hq_d[12].den;
    dv0.sr    = hq_d[12].num[55:25];
    dv0.sl    = hq_d[12].num[24:0];
    dv0.sqo   = '0;
    dv0.spos  = hq_d[12].pos;
    dv0.press = op15.press;
    dv0.slope = op15.slope;
    for (int k = 1; k <= 25; k++) dv_next[k] = div_step(dv[k-1]);
  end

  // divider stages and output register
  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0;
      for (int k = 1; k <= 25; k++) dv[k] <= dv_next[k];
      out_q.sat_press       <= dv[25].press;
      out_q.sat_press_slope <= dv[25].slope;
      out_q.sat_humidity    <= dv[25].spos ? dv[25].sqo : '0;
      if (dv[25].hzero) begin
        out_q.humidity_slope <= '0;
      end else if (dv[25].hsat || dv[25].hqo > 25'(shu_pkg::Q24_ONE)) begin
        out_q.humidity_slope <= 25'(shu_pkg::Q24_ONE);
      end else begin
        out_q.humidity_slope <= dv[25].hqo;
      end
    end
  end

  // checks
  `SHU_ASSERT_NOW(a_qs_range, result.valid, result.data.sat_humidity <= 25'(shu_pkg::Q24_ONE), "sat_humidity above one")
  `SHU_ASSERT_NOW(a_dq_range, result.valid, result.data.humidity_slope <= 25'(shu_pkg::Q24_ONE), "humidity_slope above one")
  `SHU_ASSERT_NEXT(a_stall_hold, !en, $stable(vld), "stage valid bits moved during stall")

endmodule

FILE: tb/tb_saturation_humidity_unit.sv
// ---------------------------------------------------------------------------
// tb_saturation_humidity_unit
// Self-checking bench: drives sample requests, predicts the saturation
// pressure, slope, humidity and humidity slope of each one in fixed point,
// and compares every result in order under varying idle and stall patterns
// ---------------------------------------------------------------------------
module tb_saturation_humidity_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 200;

  // decimal coefficients: rows liquid esat, ice esat, liquid slope, ice slope
  localparam int unsigned MANT [4][7] = '{
    '{61078000, 44365185, 14289458, 26506485, 30312404, 20340809, 61368209},
    '{61091780, 50346990, 18860134, 41762237, 58247203, 48388032, 18388269},
    '{44381000, 28570026, 79380540, 12152151, 10365614, 35324218, 70902448},
    '{50303052, 37732550, 12679954, 24775631, 30056931, 21585425, 71310977}};
  localparam int EXP10 [4][7] = '{
    '{7, 8, 9, 11, 13, 15, 18}, '{7, 8, 9, 11, 13, 15, 17},
    '{8, 9, 11, 12, 14, 17, 19}, '{8, 9, 10, 12, 14, 16, 19}};

  logic clk;
  logic rst;
  shu_chan_if #(.T(shu_pkg::shu_in_t))  sample_ch ();
  shu_chan_if #(.T(shu_pkg::shu_out_t)) result_ch ();

  saturation_humidity_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .result (result_ch.source)
  );

  longint            coef_q40 [4][7];
  shu_pkg::shu_in_t  pending_samples [$];
  shu_pkg::shu_out_t expected_results [$];
  int                idle_pct;
  int                stall_pct;
  bit                hold_req;
  int                hold_cnt;
  int                cycle_cnt;
  int                error_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // decimal mantissa over ten to the exp, rounded to Q40
  function automatic longint to_q40(int unsigned mant, int ex, bit neg);
    bit [63:0] d;
    bit [63:0] q;
    bit [63:0] r;
    d = 64'd1;
    for (int i = 0; i < ex; i++) d = d * 64'd10;
    q = 64'(mant) / d;
    r = 64'(mant) % d;
    for (int i = 0; i < 40; i++) begin
      q = q << 1;
      if (r >= d - r) begin
        r = r - (d - r);
        q[0] = 1'b1;
      end else begin
        r = r + r;
      end
    end
    if (r >= d - r) q = q + 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // round(a * x / 256), half away from zero
  function automatic longint mul_celsius(longint a, longint x);
    bit        neg;
    bit [63:0] ma;
    bit [63:0] mx;
    bit [63:0] pr;
    neg = (a < 0) != (x < 0);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mx = (x < 0) ? 64'(-x) : 64'(x);
    pr = (ma * mx + 64'd128) >> 8;
    return neg ? -longint'(pr) : longint'(pr);
  endfunction

  // non-constant part of one polynomial row, Horner form
  function automatic longint poly_terms(int row, longint x);
    longint acc;
    acc = coef_q40[row][6];
    for (int k = 5; k >= 1; k--) acc = coef_q40[row][k] + mul_celsius(acc, x);
    return mul_celsius(acc, x);
  endfunction

  // hPa Q40 to pascal Q16, clamped
  function automatic bit [63:0] hpa_to_pa16(longint v);
    bit [63:0] r;
    if (v <= 0) return 64'd0;
    r = (64'(v) * 64'd100 + (64'd1 << 23)) >> 24;
    return (r > (64'(shu_pkg::P21_MAX) << 12)) ? (64'(shu_pkg::P21_MAX) << 12) : r;
  endfunction

  function automatic bit [20:0] pa16_to_q4(bit [63:0] v);
    bit [63:0] r;
    r = (v + 64'd2048) >> 12;
    return (r > 64'(shu_pkg::P21_MAX)) ? 21'(shu_pkg::P21_MAX) : 21'(r);
  endfunction

  function automatic shu_pkg::shu_out_t predict_saturation(shu_pkg::shu_in_t s);
    shu_pkg::shu_out_t o;
    longint    t;
    longint    c;
    longint    xl;
    longint    xi;
    longint    ev;
    longint    dv;
    longint    den;
    bit        warm;
    bit [63:0] e;
    bit [63:0] p;
    bit [63:0] q;
    bit [63:0] es;
    bit [63:0] ds;
    bit [63:0] qs;
    bit [63:0] dq;
    bit [63:0] f;
    bit [63:0] g;
    t = longint'(s.temp_kelvin);
    e = 64'(s.vapor_press);
    p = 64'(s.air_press);
    q = 64'(s.spec_humidity);
    c = t - shu_pkg::TRIPLE_Q8;
    xl = (c < 0) ? 0 : ((c > shu_pkg::LIQ_MAX_Q8) ? shu_pkg::LIQ_MAX_Q8 : c);
    xi = (c > 0) ? 0 : ((c < shu_pkg::ICE_MIN_Q8) ? shu_pkg::ICE_MIN_Q8 : c);
    warm = t >= shu_pkg::TRIPLE_Q8;
    ev = (warm ? coef_q40[0][0] : coef_q40[1][0]) + poly_terms(0, xl) + poly_terms(1, xi);
    dv = (warm ? coef_q40[2][0] : coef_q40[3][0]) + poly_terms(2, xl) + poly_terms(3, xi);
    es = hpa_to_pa16(ev);
    ds = hpa_to_pa16(dv);
    // saturation humidity, zero when the divisor is zero
    den = longint'(1000 * p) - longint'(378 * e);
    if (den < longint'(622 * e)) den = longint'(622 * e);
    if (den <= 0) begin
      qs = 0;
    end else begin
      qs = (((64'd622 * e) << 24) + 64'(den) / 2) / 64'(den);
      if (qs > shu_pkg::Q24_ONE) qs = shu_pkg::Q24_ONE;
    end
    // humidity slope, zero when esat is zero
    if (es == 0) begin
      dq = 0;
    end else begin
      f = 64'(shu_pkg::Q24_ONE) + (64'd6077 * q + 64'd5000) / 64'd10000;
      g = (q * f + (64'd1 << 23)) >> 24;
      dq = (ds * g + es / 2) / es;
      if (dq > shu_pkg::Q24_ONE) dq = shu_pkg::Q24_ONE;
    end
    o.sat_press       = pa16_to_q4(es);
    o.sat_press_slope = pa16_to_q4(ds);
    o.sat_humidity    = qs[24:0];
    o.humidity_slope  = dq[24:0];
    return o;
  endfunction

  // request driver: expectation recorded at each accepted request
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.data  <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        expected_results.push_back(predict_saturation(sample_ch.data));
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
          sample_ch.valid <= 1'b1;
          sample_ch.data  <= pending_samples.pop_front();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (!hold_req) hold_cnt <= 0;
    else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end

  // result monitor and ready generation
  always @(posedge clk) begin
    shu_pkg::shu_out_t exp_r;
    shu_pkg::shu_out_t act;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !(hold_req && hold_cnt < HOLD_CYCLES - 1)
                         && ($urandom_range(99) >= stall_pct);
      if (result_ch.valid && result_ch.ready) begin
        act = result_ch.data;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %p", act);
          error_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (act.sat_press !== exp_r.sat_press) begin
            $error("sat_press expected %0d actual %0d", exp_r.sat_press, act.sat_press);
            error_cnt++;
          end
          if (act.sat_press_slope !== exp_r.sat_press_slope) begin
            $error("sat_press_slope expected %0d actual %0d",
                   exp_r.sat_press_slope, act.sat_press_slope);
            error_cnt++;
          end
          if (act.sat_humidity !== exp_r.sat_humidity) begin
            $error("sat_humidity expected %0d actual %0d",
                   exp_r.sat_humidity, act.sat_humidity);
            error_cnt++;
          end
          if (act.humidity_slope !== exp_r.humidity_slope) begin
            $error("humidity_slope expected %0d actual %0d",
                   exp_r.humidity_slope, act.humidity_slope);
            error_cnt++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic shu_pkg::shu_in_t make_sample(int t, int e, int p, int q);
    shu_pkg::shu_in_t s;
    s.temp_kelvin   = 17'(t);
    s.vapor_press   = 21'(e);
    s.air_press     = 21'(p);
    s.spec_humidity = 25'(q);
    return s;
  endfunction

  function automatic shu_pkg::shu_in_t random_sample();
    int t;
    int e;
    int p;
    int q;
    if ($urandom_range(9) < 8) t = $urandom_range(102400, 38400);
    else t = $urandom_range(131071);
    case ($urandom_range(3))
      0: e = $urandom_range(2097151);
      1: e = $urandom_range(80000);
      2: e = 0;
      default: e = $urandom_range(2097151, 2000000);
    endcase
    case ($urandom_range(3))
      0: p = $urandom_range(2097151);
      1: p = $urandom_range(1700000, 1400000);
      2: p = $urandom_range(1000);
      default: p = $urandom_range(2097151, 2000000);
    endcase
    if ($urandom_range(9) < 8) q = $urandom_range(shu_pkg::Q24_ONE);
    else q = $urandom_range(33554431);
    return make_sample(t, e, p, q);
  endfunction

  task automatic wait_drained();
    while (pending_samples.size() > 0 || sample_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_random(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) pending_samples.push_back(random_sample());
    wait_drained();
  endtask

  initial begin
    for (int r = 0; r < 4; r++)
      for (int k = 0; k < 7; k++)
        coef_q40[r][k] = to_q40(MANT[r][k], EXP10[r][k], r == 2 && k == 6);
    rst       = 1'b1;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    hold_cnt  = 0;
    cycle_cnt = 0;
    error_cnt = 0;
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    result_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: temperature extremes, the triple point, clamp edges, zero divisors
    pending_samples.push_back(make_sample(0, 0, 0, 0));
    pending_samples.push_back(make_sample(131071, 2097151, 2097151, 33554431));
    pending_samples.push_back(make_sample(38400, 1000, 1600000, shu_pkg::Q24_ONE));
    pending_samples.push_back(make_sample(102400, 1500000, 1620000, 8000000));
    pending_samples.push_back(make_sample(69928, 9800, 1621000, 60000));
    pending_samples.push_back(make_sample(69929, 9800, 1621000, 60000));
    pending_samples.push_back(make_sample(69930, 9800, 1621000, 60000));
    pending_samples.push_back(make_sample(69929 - 15360, 20, 1600000, 100));
    pending_samples.push_back(make_sample(69929 - 15361, 20, 1600000, 100));
    pending_samples.push_back(make_sample(69929 + 25600, 1620000, 1620000, 300000));
    pending_samples.push_back(make_sample(69929 + 25601, 1620000, 0, 300000));
    pending_samples.push_back(make_sample(75000, 2097151, 0, 33554431));
    pending_samples.push_back(make_sample(75000, 0, 2097151, shu_pkg::Q24_ONE + 1));
    pending_samples.push_back(make_sample(60000, 1, 1, 1));
    pending_samples.push_back(make_sample(80000, 1398101, 2097151, 16777215));
    pending_samples.push_back(make_sample(87381, 699050, 1048575, 5592405));
    wait_drained();

    run_random(100, 0, 0);
    run_random(90, 63, 0);
    run_random(90, 0, 63);
    run_random(90, 24, 24);

    // receiver holds off while requests keep coming, pipeline fills and backs up
    hold_req  = 1'b1;
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < 60; i++) pending_samples.push_back(random_sample());
    wait_drained();
    hold_req = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
